// File: sv/ofd_pkg.sv
// Shared constants, register indexes and types of the occupancy frontier detector.
package ofd_pkg;

    // Register file
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 32;

    localparam logic [CFG_IDX_W-1:0] CFG_MAP_WIDTH  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_MAP_HEIGHT = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_ORG_X      = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_ORG_Y      = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_CELL_SIZE  = 3'd4;

    localparam int MAP_WIDTH_W  = 11;
    localparam int ROW_W        = 16;
    localparam int COORD_W      = 32;

    localparam logic [MAP_WIDTH_W-1:0] MAP_WIDTH_RST  = 11'd1024;
    localparam logic [ROW_W-1:0]       MAP_HEIGHT_RST = 16'd1024;
    localparam logic [COORD_W-1:0]     CELL_SIZE_RST  = 32'd3277;

    // Sizing defaults
    localparam int DEF_MAX_WIDTH = 1024;
    localparam int MQ_DEPTH      = 4;
    localparam int OQ_DEPTH      = 4;

    // Input item codes
    localparam logic              MODE_CELL    = 1'b0;
    localparam logic signed [7:0] CELL_FREE    = 8'sd0;
    localparam logic signed [7:0] CELL_UNKNOWN = -8'sd1;

    // Cell marks: bit 0 free, bit 1 unknown
    localparam logic [1:0] MARK_NONE    = 2'b00;
    localparam logic [1:0] MARK_FREE    = 2'b01;
    localparam logic [1:0] MARK_UNKNOWN = 2'b10;

    // 3 columns x 3 rows of 2-bit marks
    localparam int WIN_W = 18;

    localparam logic signed [COORD_W-1:0] SAT_MAX = 32'sh7FFF_FFFF;
    localparam logic signed [COORD_W-1:0] SAT_MIN = 32'sh8000_0000;

    typedef struct packed {
        logic signed [COORD_W-1:0] org_x;
        logic signed [COORD_W-1:0] org_y;
        logic        [COORD_W-1:0] cell_size;
    } t_geom;

endpackage

// File: sv/ofd_fifo.sv
// Small register FIFO with occupancy count, used for the candidate and result queues.
module ofd_fifo
    import ofd_pkg::*;
#(
    parameter int WIDTH = 1,
    parameter int DEPTH = MQ_DEPTH,
    localparam int PW   = (DEPTH > 1) ? $clog2(DEPTH) : 1,
    localparam int CNTW = $clog2(DEPTH + 1)
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  logic [WIDTH-1:0] i_data,
    input  logic             i_pop,
    output logic [WIDTH-1:0] o_data,
    output logic [CNTW-1:0]  o_count,
    output logic             o_empty
);

    logic [WIDTH-1:0] r_data [DEPTH];
    logic [PW-1:0]    r_wr_ptr, n_wr_ptr;
    logic [PW-1:0]    r_rd_ptr, n_rd_ptr;
    logic [CNTW-1:0]  r_count, n_count;

    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (i_push) begin
            n_wr_ptr = (r_wr_ptr == PW'(DEPTH - 1)) ? '0 : r_wr_ptr + PW'(1);
        end
        if (i_pop) begin
            n_rd_ptr = (r_rd_ptr == PW'(DEPTH - 1)) ? '0 : r_rd_ptr + PW'(1);
        end
        if (i_push && !i_pop) begin
            n_count = r_count + CNTW'(1);
        end else if (!i_push && i_pop) begin
            n_count = r_count - CNTW'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_data[r_wr_ptr] <= i_data;
        end
    end

    assign o_data  = r_data[r_rd_ptr];
    assign o_count = r_count;
    assign o_empty = (r_count == '0);

`ifndef SYNTH
    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(i_push && (r_count == CNTW'(DEPTH))))
        else $error("fifo push while full");

    a_no_underflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(i_pop && (r_count == '0)))
        else $error("fifo pop while empty");

    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_count <= CNTW'(DEPTH)))
        else $error("fifo count out of range");
`endif

endmodule

// File: sv/ofd_front.sv
// Front part: raster counters, cell classification, line store and 3x3 window decision.
module ofd_front
    import ofd_pkg::*;
#(
    parameter int MAX_WIDTH = DEF_MAX_WIDTH,
    parameter int Q_DEPTH   = MQ_DEPTH,
    localparam int CW  = $clog2(MAX_WIDTH),
    localparam int WW  = $clog2(MAX_WIDTH + 1),
    localparam int QCW = $clog2(Q_DEPTH + 1)
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_restart,
    input  logic [MAP_WIDTH_W-1:0] i_map_width,
    input  logic [ROW_W-1:0]       i_map_height,
    input  logic                   i_push,
    input  logic                   i_mode,
    input  logic signed [7:0]      i_cell_value,
    input  logic [QCW-1:0]         i_q_count,
    output logic                   o_full,
    output logic                   o_cand_push,
    output logic [CW-1:0]          o_cand_col,
    output logic [ROW_W-1:0]       o_cand_row,
    output logic                   o_cand_last
);

    logic             accept;
    logic [WW-1:0]    w_eff;
    logic [ROW_W-1:0] h_eff;

    logic [CW-1:0]    r_col, n_col;
    logic [ROW_W-1:0] r_row, n_row;
    logic [WW-1:0]    r_flush, n_flush;

    logic             padding;
    logic             is_final;
    logic             wrap;
    logic             col_nz;
    logic [ROW_W:0]   erow;
    logic [ROW_W:0]   crow;
    logic [CW-1:0]    ccol;
    logic             decide;
    logic [1:0]       mark;

    // Line store: [1:0] row two above, [3:2] row one above
    logic [3:0]       r_store [MAX_WIDTH];
    logic [3:0]       r_rd;

    logic             r_b_valid;
    logic [CW-1:0]    r_b_col;
    logic [1:0]       r_b_mark;
    logic             r_b_decide;
    logic [CW-1:0]    r_b_ccol;
    logic [ROW_W-1:0] r_b_crow;
    logic             r_b_left, r_b_right, r_b_top, r_b_bottom;
    logic             r_b_last;
    logic             r_b_final;
    logic             r_b_fwd;
    logic [3:0]       r_b_fwd_data;
    logic [WIN_W-1:0] r_window;

    logic [3:0]       b_entry;
    logic [1:0]       b_upper, b_middle;
    logic [WIN_W-1:0] b_window;
    logic             b_hit;

    always_comb begin
        if (i_map_width == '0) begin
            w_eff = WW'(1);
        end else if (32'(i_map_width) > 32'(MAX_WIDTH)) begin
            w_eff = WW'(MAX_WIDTH);
        end else begin
            w_eff = WW'(i_map_width);
        end
        h_eff = (i_map_height == '0) ? ROW_W'(1) : i_map_height;
    end

    assign o_full = ({1'b0, i_q_count} + (QCW + 1)'(r_b_valid)) >= (QCW + 1)'(Q_DEPTH);
    assign accept = i_push && !o_full;

    // Classify the incoming position
    always_comb begin
        padding  = (r_row >= h_eff);
        is_final = padding && (r_flush >= w_eff);
        wrap     = ((WW'(r_col) + WW'(1)) == w_eff);
        col_nz   = (r_col != '0);
        erow     = {1'b0, r_row} + (ROW_W + 1)'(is_final);
        decide   = col_nz ? (erow >= (ROW_W + 1)'(1)) : (erow >= (ROW_W + 1)'(2));
        crow     = col_nz ? erow - (ROW_W + 1)'(1) : erow - (ROW_W + 1)'(2);
        ccol     = col_nz ? r_col - CW'(1) : CW'(w_eff - WW'(1));
        mark     = MARK_NONE;
        if (!padding && (i_mode == MODE_CELL)) begin
            if (i_cell_value == CELL_FREE) begin
                mark = MARK_FREE;
            end else if (i_cell_value == CELL_UNKNOWN) begin
                mark = MARK_UNKNOWN;
            end
        end
    end

    always_comb begin
        n_col   = r_col;
        n_row   = r_row;
        n_flush = r_flush;
        if (i_restart) begin
            n_col   = '0;
            n_row   = '0;
            n_flush = '0;
        end else if (accept) begin
            if (is_final) begin
                n_col   = '0;
                n_row   = '0;
                n_flush = '0;
            end else begin
                if (padding) begin
                    n_flush = r_flush + WW'(1);
                end
                if (wrap) begin
                    n_col = '0;
                    if (!padding) begin
                        n_row = r_row + ROW_W'(1);
                    end
                end else begin
                    n_col = r_col + CW'(1);
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col     <= '0;
            r_row     <= '0;
            r_flush   <= '0;
            r_b_valid <= 1'b0;
        end else begin
            r_col     <= n_col;
            r_row     <= n_row;
            r_flush   <= n_flush;
            r_b_valid <= accept;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_b_col      <= r_col;
            r_b_mark     <= mark;
            r_b_decide   <= decide && (crow < {1'b0, h_eff});
            r_b_ccol     <= ccol;
            r_b_crow     <= crow[ROW_W-1:0];
            r_b_left     <= (ccol == '0);
            r_b_right    <= (WW'(ccol) == (w_eff - WW'(1)));
            r_b_top      <= (crow == '0);
            r_b_bottom   <= (crow == ({1'b0, h_eff} - (ROW_W + 1)'(1)));
            r_b_last     <= (WW'(ccol) == (w_eff - WW'(1)))
                         && (crow == ({1'b0, h_eff} - (ROW_W + 1)'(1)));
            r_b_final    <= is_final;
            // Bypass the entry that the item in flight writes this cycle
            r_b_fwd      <= r_b_valid && (r_b_col == r_col);
            r_b_fwd_data <= {r_b_mark, b_middle};
        end
    end

    // Line store: read at accept, written back in the next cycle
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_rd <= r_store[r_col];
        end
        if (r_b_valid) begin
            r_store[r_b_col] <= {r_b_mark, b_middle};
        end
    end

    always_comb begin
        b_entry  = r_b_fwd ? r_b_fwd_data : r_rd;
        b_upper  = b_entry[1:0];
        b_middle = b_entry[3:2];
        b_window = {r_b_mark, b_middle, b_upper, r_window[WIN_W-1:6]};
    end

    always_comb begin
        b_hit = 1'b0;
        for (int k = 0; k < 3; k++) begin
            for (int r = 0; r < 3; r++) begin
                if (!(k == 1 && r == 1) && !(k == 0 && r_b_left) && !(k == 2 && r_b_right)
                    && !(r == 0 && r_b_top) && !(r == 2 && r_b_bottom)
                    && ((b_window[6*k + 2*r +: 2] & MARK_UNKNOWN) != MARK_NONE)) begin
                    b_hit = 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_window <= '0;
        end else if (i_restart) begin
            r_window <= '0;
        end else if (r_b_valid) begin
            r_window <= r_b_final ? '0 : b_window;
        end
    end

    assign o_cand_push = r_b_valid && r_b_decide && b_hit
                      && ((b_window[8 +: 2] & MARK_FREE) != MARK_NONE);
    assign o_cand_col  = r_b_ccol;
    assign o_cand_row  = r_b_crow;
    assign o_cand_last = r_b_last;

`ifndef SYNTH
    a_col_in_row: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (WW'(r_col) < w_eff))
        else $error("column counter beyond map width");

    a_flush_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_flush <= w_eff) && (r_row <= h_eff))
        else $error("row or flush counter beyond frame");

    a_fwd_source: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_b_valid && r_b_fwd) |-> $past(r_b_valid))
        else $error("line store bypass without an item in flight");
`endif

endmodule

// File: sv/ofd_back.sv
// Back part: world coordinates of frontier cells, multiply then round and saturate.
module ofd_back
    import ofd_pkg::*;
#(
    parameter int MAX_WIDTH = DEF_MAX_WIDTH,
    parameter int Q_DEPTH   = OQ_DEPTH,
    localparam int CW   = $clog2(MAX_WIDTH),
    localparam int QCW  = $clog2(Q_DEPTH + 1),
    localparam int PXW  = CW + 1 + COORD_W,
    localparam int PYW  = ROW_W + 1 + COORD_W
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  t_geom                     i_geom,
    input  logic                      i_q_empty,
    input  logic [CW-1:0]             i_q_col,
    input  logic [ROW_W-1:0]          i_q_row,
    input  logic                      i_q_last,
    output logic                      o_q_pop,
    input  logic [QCW-1:0]            i_oq_count,
    output logic                      o_oq_push,
    output logic [CW-1:0]             o_oq_col,
    output logic [ROW_W-1:0]          o_oq_row,
    output logic signed [COORD_W-1:0] o_oq_world_x,
    output logic signed [COORD_W-1:0] o_oq_world_y,
    output logic                      o_oq_last
);

    // origin + round_half_up(prod / 2), saturated to 32 bits
    function automatic logic signed [COORD_W-1:0] f_place(
        input logic signed [COORD_W-1:0] org,
        input logic [63:0]               prod
    );
        logic [64:0]        inc;
        logic signed [65:0] sum;
        inc = {1'b0, prod} + 65'd1;
        sum = $signed({{34{org[COORD_W-1]}}, org}) + $signed({2'b00, inc[64:1]});
        if (sum > 66'(SAT_MAX)) begin
            return SAT_MAX;
        end else if (sum < 66'(SAT_MIN)) begin
            return SAT_MIN;
        end
        return sum[COORD_W-1:0];
    endfunction

    logic             r_m_valid;
    logic [CW-1:0]    r_m_col;
    logic [ROW_W-1:0] r_m_row;
    logic             r_m_last;
    logic [PXW-1:0]   r_m_prod_x;
    logic [PYW-1:0]   r_m_prod_y;

    logic [PXW-1:0]   m_idx_x, m_size_x;
    logic [PYW-1:0]   m_idx_y, m_size_y;

    // Take a candidate only when the output queue has room for it and the one in flight
    assign o_q_pop = !i_q_empty
                  && (({1'b0, i_oq_count} + (QCW + 1)'(r_m_valid)) < (QCW + 1)'(Q_DEPTH));

    always_comb begin
        m_idx_x  = PXW'({i_q_col, 1'b1});
        m_size_x = PXW'(i_geom.cell_size);
        m_idx_y  = PYW'({i_q_row, 1'b1});
        m_size_y = PYW'(i_geom.cell_size);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_m_valid <= 1'b0;
        end else begin
            r_m_valid <= o_q_pop;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_q_pop) begin
            r_m_col    <= i_q_col;
            r_m_row    <= i_q_row;
            r_m_last   <= i_q_last;
            r_m_prod_x <= m_idx_x * m_size_x;
            r_m_prod_y <= m_idx_y * m_size_y;
        end
    end

    assign o_oq_push    = r_m_valid;
    assign o_oq_col     = r_m_col;
    assign o_oq_row     = r_m_row;
    assign o_oq_last    = r_m_last;
    assign o_oq_world_x = f_place(i_geom.org_x, 64'(r_m_prod_x));
    assign o_oq_world_y = f_place(i_geom.org_y, 64'(r_m_prod_y));

endmodule

// File: sv/occupancy_frontier_detector.sv
// Top level of the occupancy frontier detector: register file and part interconnect.
//
// Takes one map cell or flush tick per clock cycle while full is low and reports every
// free cell that touches an unknown in-map 8-neighbour, in raster order, with its
// centre in world coordinates. A cell is decided when the item map_width+1 positions
// after it is accepted, so a frame of width W and height H needs W*H cells followed
// by W+1 flush ticks. On its way to the result queue each decision passes the line
// store read, the window decision, the coordinate multiply and round and saturate.
// The sustained rate of one item per cycle while full is low is set by the single
// line store memory, which is read at accept and written back in the following
// cycle, with a bypass when two consecutive items hit the same column. The line
// store needs no clearing pass after reset: entries of the rows above row 0 are
// never taken as neighbours. full rises when the internal candidate queue has no
// room left, for instance while pop is held low. Write the registers only while the
// block is idle; a write to the map width or height restarts the frame.
module occupancy_frontier_detector
    import ofd_pkg::*;
#(
    parameter int MAX_WIDTH = DEF_MAX_WIDTH,
    localparam int CW = $clog2(MAX_WIDTH)
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      push,
    output logic                      full,
    input  logic                      i_mode,
    input  logic signed [7:0]         i_cell_value,
    output logic                      empty,
    input  logic                      pop,
    output logic [CW-1:0]             o_cell_col,
    output logic [ROW_W-1:0]          o_cell_row,
    output logic signed [COORD_W-1:0] o_world_x,
    output logic signed [COORD_W-1:0] o_world_y,
    output logic                      o_last_of_frame,
    input  logic                      i_cfg_we,
    input  logic [CFG_IDX_W-1:0]      i_cfg_index,
    input  logic [CFG_DATA_W-1:0]     i_cfg_data
);

    localparam int MQW  = CW + ROW_W + 1;
    localparam int OQW  = CW + ROW_W + 2 * COORD_W + 1;
    localparam int MQCW = $clog2(MQ_DEPTH + 1);
    localparam int OQCW = $clog2(OQ_DEPTH + 1);

    logic [MAP_WIDTH_W-1:0] r_map_width;
    logic [ROW_W-1:0]       r_map_height;
    logic [COORD_W-1:0]     r_org_x;
    logic [COORD_W-1:0]     r_org_y;
    logic [COORD_W-1:0]     r_cell_size;
    logic                   cfg_restart;
    t_geom                  geom;

    logic                   cand_push;
    logic [CW-1:0]          cand_col;
    logic [ROW_W-1:0]       cand_row;
    logic                   cand_last;
    logic [MQW-1:0]         mq_wdata, mq_rdata;
    logic [MQCW-1:0]        mq_count;
    logic                   mq_empty;
    logic                   mq_pop;

    logic                   oq_push;
    logic [CW-1:0]          oq_col;
    logic [ROW_W-1:0]       oq_row;
    logic signed [COORD_W-1:0] oq_world_x, oq_world_y;
    logic                   oq_last;
    logic [OQW-1:0]         oq_wdata, oq_rdata;
    logic [OQCW-1:0]        oq_count;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_map_width  <= MAP_WIDTH_RST;
            r_map_height <= MAP_HEIGHT_RST;
            r_org_x      <= '0;
            r_org_y      <= '0;
            r_cell_size  <= CELL_SIZE_RST;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                CFG_MAP_WIDTH:  r_map_width  <= i_cfg_data[MAP_WIDTH_W-1:0];
                CFG_MAP_HEIGHT: r_map_height <= i_cfg_data[ROW_W-1:0];
                CFG_ORG_X:      r_org_x      <= i_cfg_data[COORD_W-1:0];
                CFG_ORG_Y:      r_org_y      <= i_cfg_data[COORD_W-1:0];
                CFG_CELL_SIZE:  r_cell_size  <= i_cfg_data[COORD_W-1:0];
                default: ;
            endcase
        end
    end

    // Restart the frame on any size write
    assign cfg_restart = i_cfg_we
                      && ((i_cfg_index == CFG_MAP_WIDTH) || (i_cfg_index == CFG_MAP_HEIGHT));

    assign geom.org_x     = $signed(r_org_x);
    assign geom.org_y     = $signed(r_org_y);
    assign geom.cell_size = r_cell_size;

    ofd_front #(
        .MAX_WIDTH (MAX_WIDTH),
        .Q_DEPTH   (MQ_DEPTH)
    ) u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_restart    (cfg_restart),
        .i_map_width  (r_map_width),
        .i_map_height (r_map_height),
        .i_push       (push),
        .i_mode       (i_mode),
        .i_cell_value (i_cell_value),
        .i_q_count    (mq_count),
        .o_full       (full),
        .o_cand_push  (cand_push),
        .o_cand_col   (cand_col),
        .o_cand_row   (cand_row),
        .o_cand_last  (cand_last)
    );

    assign mq_wdata = {cand_col, cand_row, cand_last};

    ofd_fifo #(
        .WIDTH (MQW),
        .DEPTH (MQ_DEPTH)
    ) u_cand_q (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (cand_push),
        .i_data  (mq_wdata),
        .i_pop   (mq_pop),
        .o_data  (mq_rdata),
        .o_count (mq_count),
        .o_empty (mq_empty)
    );

    ofd_back #(
        .MAX_WIDTH (MAX_WIDTH),
        .Q_DEPTH   (OQ_DEPTH)
    ) u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_geom       (geom),
        .i_q_empty    (mq_empty),
        .i_q_col      (mq_rdata[MQW-1 -: CW]),
        .i_q_row      (mq_rdata[ROW_W:1]),
        .i_q_last     (mq_rdata[0]),
        .o_q_pop      (mq_pop),
        .i_oq_count   (oq_count),
        .o_oq_push    (oq_push),
        .o_oq_col     (oq_col),
        .o_oq_row     (oq_row),
        .o_oq_world_x (oq_world_x),
        .o_oq_world_y (oq_world_y),
        .o_oq_last    (oq_last)
    );

    assign oq_wdata = {oq_col, oq_row, oq_world_x, oq_world_y, oq_last};

    ofd_fifo #(
        .WIDTH (OQW),
        .DEPTH (OQ_DEPTH)
    ) u_result_q (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (oq_push),
        .i_data  (oq_wdata),
        .i_pop   (pop && !empty),
        .o_data  (oq_rdata),
        .o_count (oq_count),
        .o_empty (empty)
    );

    assign o_cell_col      = oq_rdata[OQW-1 -: CW];
    assign o_cell_row      = oq_rdata[2*COORD_W + ROW_W -: ROW_W];
    assign o_world_x       = $signed(oq_rdata[2*COORD_W -: COORD_W]);
    assign o_world_y       = $signed(oq_rdata[COORD_W:1]);
    assign o_last_of_frame = oq_rdata[0];

endmodule

// File: tb/sv/tb_occupancy_frontier_detector.sv
// Self-checking bench for the occupancy frontier detector: scripted frames, random frames, idling.
module tb_occupancy_frontier_detector;
    import ofd_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int COL_W        = $clog2(DEF_MAX_WIDTH);
    localparam int SETTLE       = 16;
    localparam int TAIL         = 32;
    localparam int HOLD_CYCLES  = 400;
    localparam int RANDOM_ITEMS = 1125;
    localparam int HOLD_FRAME   = 3;
    localparam int WIDE_FRAME   = 5;
    localparam int WIDE_TAIL    = 64;
    localparam int PAUSE_FRAME  = 9;
    localparam int TALL_HEIGHT  = 65535;

    localparam logic                 MODE_FLUSH    = 1'b1;
    localparam logic [CFG_IDX_W-1:0] CFG_UNUSED_LO = 3'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_UNUSED_HI = 3'd7;

    typedef struct packed {
        logic [COL_W-1:0]          col;
        logic [ROW_W-1:0]          row;
        logic signed [COORD_W-1:0] x;
        logic signed [COORD_W-1:0] y;
        logic                      last_cell;
    } t_frontier;

    localparam t_frontier NO_HIT = '0;

    // ROW_ITEM is checked against the predictor, ROW_NONE and ROW_HIT carry a typed outcome
    typedef enum logic [1:0] {ROW_CFG, ROW_ITEM, ROW_NONE, ROW_HIT} t_row_kind;

    typedef struct packed {
        t_row_kind                 kind;
        logic [CFG_IDX_W-1:0]      idx;
        logic [CFG_DATA_W-1:0]     data;
        logic                      m;
        logic signed [7:0]         v;
        t_frontier                 hit;
    } t_script_row;

    typedef enum logic [1:0] {IDLE_NONE, IDLE_SEND, IDLE_RECV, IDLE_BOTH} t_idle_mode;

    logic                      i_clk;
    logic                      i_rst_n;
    logic                      push;
    logic                      full;
    logic                      i_mode;
    logic signed [7:0]         i_cell_value;
    logic                      empty;
    logic                      pop;
    logic [COL_W-1:0]          o_cell_col;
    logic [ROW_W-1:0]          o_cell_row;
    logic signed [COORD_W-1:0] o_world_x;
    logic signed [COORD_W-1:0] o_world_y;
    logic                      o_last_of_frame;
    logic                      i_cfg_we;
    logic [CFG_IDX_W-1:0]      i_cfg_index;
    logic [CFG_DATA_W-1:0]     i_cfg_data;

    occupancy_frontier_detector DUT (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .push            (push),
        .full            (full),
        .i_mode          (i_mode),
        .i_cell_value    (i_cell_value),
        .empty           (empty),
        .pop             (pop),
        .o_cell_col      (o_cell_col),
        .o_cell_row      (o_cell_row),
        .o_world_x       (o_world_x),
        .o_world_y       (o_world_y),
        .o_last_of_frame (o_last_of_frame),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_index     (i_cfg_index),
        .i_cfg_data      (i_cfg_data)
    );

    // Predictor state
    logic [1:0]                marks_upper  [DEF_MAX_WIDTH];
    logic [1:0]                marks_middle [DEF_MAX_WIDTH];
    logic [WIN_W-1:0]          mark_window;
    int unsigned               pos_col;
    int unsigned               pos_row;
    int unsigned               pos_flush;
    logic [MAP_WIDTH_W-1:0]    reg_width;
    logic [ROW_W-1:0]          reg_height;
    logic signed [COORD_W-1:0] reg_org_x;
    logic signed [COORD_W-1:0] reg_org_y;
    logic [COORD_W-1:0]        reg_cell;

    t_frontier   pending_frontiers[$];
    t_script_row script[$];
    t_idle_mode  idle_mode;
    int          hold_left;
    int          errors;

    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    initial begin
        #1_000_000;
        $display("tb_occupancy_frontier_detector: errors");
        $finish;
    end

    function automatic int unsigned eff_width();
        if (reg_width == '0) return 1;
        if (int'(reg_width) > DEF_MAX_WIDTH) return DEF_MAX_WIDTH;
        return int'(reg_width);
    endfunction

    function automatic int unsigned eff_height();
        return (reg_height == '0) ? 1 : int'(reg_height);
    endfunction

    function automatic void rewind_frame();
        mark_window = '0;
        pos_col     = 0;
        pos_row     = 0;
        pos_flush   = 0;
    endfunction

    // origin + (index + 0.5) * cell edge, rounded half up, saturated to 32 bits
    function automatic logic signed [COORD_W-1:0] cell_centre(logic signed [COORD_W-1:0] origin,
                                                              int unsigned index);
        longint span;
        longint sum;
        span = (longint'(index) * 2 + 1) * longint'(reg_cell);
        sum  = longint'(origin) + ((span + 1) >>> 1);
        if (sum > longint'(SAT_MAX)) sum = longint'(SAT_MAX);
        else if (sum < longint'(SAT_MIN)) sum = longint'(SAT_MIN);
        return 32'(sum);
    endfunction

    function automatic t_frontier make_frontier(int unsigned col, int unsigned row,
                                                logic signed [COORD_W-1:0] x,
                                                logic signed [COORD_W-1:0] y, logic last_cell);
        t_frontier f;
        f.col       = COL_W'(col);
        f.row       = ROW_W'(row);
        f.x         = x;
        f.y         = y;
        f.last_cell = last_cell;
        return f;
    endfunction

    function automatic void add_cfg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
        t_script_row r;
        r      = '0;
        r.kind = ROW_CFG;
        r.idx  = idx;
        r.data = data;
        script.insert(script.size(), r);
    endfunction

    function automatic void add_cell(t_row_kind kind, logic m, logic signed [7:0] v,
                                     t_frontier hit);
        t_script_row r;
        r      = '0;
        r.kind = kind;
        r.m    = m;
        r.v    = v;
        r.hit  = hit;
        script.insert(script.size(), r);
    endfunction

    function automatic void check_field(string name, longint want, longint got);
        if (want != got) begin
            errors++;
            $display("%0t: %s expected %0d got %0d", $time, name, want, got);
        end
    endfunction

    // Advance the window by one item and decide the cell that leaves its centre
    task automatic detect_step(input logic m, input logic signed [7:0] v,
                               output bit found, output t_frontier res);
        int unsigned w, h, c, erow, ccol, crow, k, r;
        bit          pad, closing;
        logic [1:0]  mark;
        logic [5:0]  newcol;
        w       = eff_width();
        h       = eff_height();
        c       = (pos_col < w) ? pos_col : 0;
        pad     = pos_row >= h;
        closing = pad && pos_flush >= w;
        erow    = pos_row + (closing ? 1 : 0);
        mark    = MARK_NONE;
        found   = 1'b0;
        res     = NO_HIT;
        if (!pad && m == MODE_CELL) begin
            if (v == CELL_FREE) mark = MARK_FREE;
            else if (v == CELL_UNKNOWN) mark = MARK_UNKNOWN;
        end
        newcol          = {mark, marks_middle[c], marks_upper[c]};
        marks_upper[c]  = marks_middle[c];
        marks_middle[c] = mark;
        mark_window     = {newcol, mark_window[WIN_W-1:6]};

        if ((c >= 1 && erow >= 1) || (c == 0 && erow >= 2)) begin
            ccol = (c >= 1) ? c - 1 : w - 1;
            crow = (c >= 1) ? erow - 1 : erow - 2;
            if (crow < h && mark_window[8]) begin
                for (k = 0; k < 3; k++) begin
                    for (r = 0; r < 3; r++) begin
                        if ((k == 0 && ccol == 0) || (k == 2 && ccol == w - 1) ||
                            (k == 1 && r == 1) || (r == 0 && crow == 0) ||
                            (r == 2 && crow == h - 1))
                            continue;
                        if (mark_window[6 * k + 2 * r + 1]) found = 1'b1;
                    end
                end
                if (found)
                    res = make_frontier(ccol, crow, cell_centre(reg_org_x, ccol),
                                        cell_centre(reg_org_y, crow),
                                        ccol == w - 1 && crow == h - 1);
            end
        end

        if (closing) begin
            rewind_frame();
        end else begin
            if (pad) pos_flush = (pos_flush + 1) & 32'h7FF;
            c++;
            if (c >= w) begin
                c = 0;
                if (!pad) pos_row++;
            end
            pos_col = c;
        end
    endtask

    // Offer one item, hold it until the transfer, then predict its outcome
    task automatic send_item(input logic m, input logic signed [7:0] v, input t_row_kind kind,
                             input t_frontier typed);
        int        gap_pct;
        bit        found;
        t_frontier res;
        gap_pct = (idle_mode == IDLE_SEND) ? 59 : (idle_mode == IDLE_BOTH) ? 14 : 0;
        while ($urandom_range(99) < gap_pct) begin
            push <= 1'b0;
            @(posedge i_clk);
        end
        push         <= 1'b1;
        i_mode       <= m;
        i_cell_value <= v;
        do @(posedge i_clk); while (full);
        detect_step(m, v, found, res);
        case (kind)
            ROW_ITEM: if (found) pending_frontiers.insert(pending_frontiers.size(), res);
            ROW_HIT:  pending_frontiers.insert(pending_frontiers.size(), typed);
            default: ;
        endcase
    endtask

    task automatic pause_for_results();
        push <= 1'b0;
        do @(posedge i_clk); while (pending_frontiers.size() != 0);
    endtask

    // Drop the input and let the pipeline run dry before touching the registers
    task automatic settle();
        pause_for_results();
        repeat (SETTLE) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        @(posedge i_clk);
        case (idx)
            CFG_MAP_WIDTH: begin
                reg_width = data[MAP_WIDTH_W-1:0];
                rewind_frame();
            end
            CFG_MAP_HEIGHT: begin
                reg_height = data[ROW_W-1:0];
                rewind_frame();
            end
            CFG_ORG_X:     reg_org_x = data;
            CFG_ORG_Y:     reg_org_y = data;
            CFG_CELL_SIZE: reg_cell = data;
            default: ;
        endcase
        i_cfg_we <= 1'b0;
        @(posedge i_clk);
    endtask

    // Result side: check each transfer, stall at random or for a requested hold-off
    initial begin
        t_frontier want;
        int        stall_pct;
        pop <= 1'b0;
        wait (i_rst_n === 1'b1);
        forever begin
            @(posedge i_clk);
            if (pop && !empty) begin
                if (pending_frontiers.size() == 0) begin
                    errors++;
                    $display("%0t: unexpected frontier col %0d row %0d", $time,
                             o_cell_col, o_cell_row);
                end else begin
                    want = pending_frontiers.pop_front();
                    check_field("cell_col", want.col, o_cell_col);
                    check_field("cell_row", want.row, o_cell_row);
                    check_field("world_x", want.x, o_world_x);
                    check_field("world_y", want.y, o_world_y);
                    check_field("last_of_frame", want.last_cell, o_last_of_frame);
                end
            end
            stall_pct = (idle_mode == IDLE_RECV) ? 59 : (idle_mode == IDLE_BOTH) ? 14 : 0;
            if (hold_left > 0) begin
                hold_left--;
                pop <= 1'b0;
            end else begin
                pop <= ($urandom_range(99) >= stall_pct);
            end
        end
    end

    initial begin
        t_script_row       row;
        int                n, frame_no, cells_sent, roll, wsel, hsel, i, limit;
        int unsigned       w, h, total;
        logic              m;
        logic signed [7:0] v;
        bit                dense;

        i_rst_n      <= 1'b0;
        push         <= 1'b0;
        i_mode       <= MODE_CELL;
        i_cell_value <= CELL_FREE;
        i_cfg_we     <= 1'b0;
        i_cfg_index  <= CFG_MAP_WIDTH;
        i_cfg_data   <= '0;
        errors     = 0;
        hold_left  = 0;
        idle_mode  = IDLE_NONE;
        reg_width  = MAP_WIDTH_RST;
        reg_height = MAP_HEIGHT_RST;
        reg_org_x  = '0;
        reg_org_y  = '0;
        reg_cell   = CELL_SIZE_RST;
        for (n = 0; n < DEF_MAX_WIDTH; n++) begin
            marks_upper[n]  = MARK_NONE;
            marks_middle[n] = MARK_NONE;
        end
        rewind_frame();

        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Nothing can be decided by the first item after reset
        add_cell(ROW_NONE, MODE_CELL, -8'sd128, NO_HIT);
        add_cfg(CFG_MAP_WIDTH, 32'd2);
        add_cfg(CFG_MAP_HEIGHT, 32'd1);
        add_cfg(CFG_ORG_X, 32'd0);
        add_cfg(CFG_ORG_Y, 32'd0);
        add_cfg(CFG_CELL_SIZE, 32'h0001_0000);
        // 2x1 map, free then unknown: the left cell is a frontier
        add_cell(ROW_NONE, MODE_CELL, CELL_FREE, NO_HIT);
        add_cell(ROW_NONE, MODE_CELL, CELL_UNKNOWN, NO_HIT);
        add_cell(ROW_NONE, MODE_FLUSH, CELL_FREE, NO_HIT);
        add_cell(ROW_HIT, MODE_FLUSH, CELL_FREE,
                 make_frontier(0, 0, 32'sh0000_8000, 32'sh0000_8000, 1'b0));
        add_cell(ROW_NONE, MODE_FLUSH, CELL_FREE, NO_HIT);
        // Mirrored: the last cell of the map is the frontier
        add_cell(ROW_NONE, MODE_CELL, CELL_UNKNOWN, NO_HIT);
        add_cell(ROW_NONE, MODE_CELL, CELL_FREE, NO_HIT);
        add_cell(ROW_NONE, MODE_FLUSH, CELL_FREE, NO_HIT);
        add_cell(ROW_NONE, MODE_FLUSH, CELL_FREE, NO_HIT);
        add_cell(ROW_HIT, MODE_FLUSH, CELL_FREE,
                 make_frontier(1, 0, 32'sh0001_8000, 32'sh0000_8000, 1'b1));
        // x saturates high, y lands exactly on zero
        add_cfg(CFG_ORG_X, 32'h7FFF_FFFF);
        add_cfg(CFG_ORG_Y, 32'h8000_0000);
        add_cfg(CFG_CELL_SIZE, 32'hFFFF_FFFF);
        add_cell(ROW_NONE, MODE_CELL, CELL_FREE, NO_HIT);
        add_cell(ROW_NONE, MODE_CELL, CELL_UNKNOWN, NO_HIT);
        add_cell(ROW_NONE, MODE_FLUSH, CELL_FREE, NO_HIT);
        add_cell(ROW_HIT, MODE_FLUSH, CELL_FREE,
                 make_frontier(0, 0, SAT_MAX, 32'sh0000_0000, 1'b0));
        add_cell(ROW_NONE, MODE_FLUSH, CELL_FREE, NO_HIT);
        // Writes past the register list are dropped
        add_cfg(CFG_UNUSED_HI, 32'hFFFF_FFFF);
        add_cfg(CFG_UNUSED_LO, 32'h0000_0000);
        // Zero sizes act as a single cell
        add_cfg(CFG_MAP_WIDTH, 32'd0);
        add_cfg(CFG_MAP_HEIGHT, 32'd0);
        add_cell(ROW_ITEM, MODE_CELL, CELL_FREE, NO_HIT);
        add_cell(ROW_ITEM, MODE_FLUSH, CELL_UNKNOWN, NO_HIT);
        add_cell(ROW_ITEM, MODE_FLUSH, CELL_FREE, NO_HIT);
        // 2x2 with a flush tick inside the map and cells offered after the last row
        add_cfg(CFG_MAP_WIDTH, 32'hFFFF_F802);
        add_cfg(CFG_MAP_HEIGHT, 32'hABCD_0002);
        add_cfg(CFG_CELL_SIZE, 32'd3277);
        add_cell(ROW_ITEM, MODE_CELL, CELL_FREE, NO_HIT);
        add_cell(ROW_ITEM, MODE_FLUSH, CELL_FREE, NO_HIT);
        add_cell(ROW_ITEM, MODE_CELL, CELL_UNKNOWN, NO_HIT);
        add_cell(ROW_ITEM, MODE_CELL, CELL_FREE, NO_HIT);
        add_cell(ROW_ITEM, MODE_CELL, CELL_UNKNOWN, NO_HIT);
        add_cell(ROW_ITEM, MODE_CELL, CELL_FREE, NO_HIT);
        add_cell(ROW_ITEM, MODE_FLUSH, 8'sd127, NO_HIT);

        foreach (script[n]) begin
            row = script[n];
            if (row.kind == ROW_CFG) begin
                settle();
                write_reg(row.idx, row.data);
            end else begin
                send_item(row.m, row.v, row.kind, row.hit);
            end
        end

        frame_no   = 0;
        cells_sent = 0;
        while (cells_sent < RANDOM_ITEMS) begin
            settle();
            idle_mode = t_idle_mode'(frame_no % 4);
            dense     = (frame_no == HOLD_FRAME);
            if (dense) begin
                wsel = 8;
                hsel = 8;
            end else if (frame_no == WIDE_FRAME) begin
                // above the line store size: acts as the full width
                wsel = 32'h7FF;
                hsel = 1;
            end else begin
                roll = $urandom_range(99);
                wsel = (roll < 5) ? 0 : (roll < 85) ? $urandom_range(1, 8) : $urandom_range(9, 40);
                roll = $urandom_range(99);
                hsel = (roll < 5) ? 0 : (roll < 9) ? TALL_HEIGHT : $urandom_range(1, 6);
            end
            write_reg(CFG_MAP_WIDTH, ($urandom() & 32'hFFFF_F800) | 32'(wsel));
            write_reg(CFG_MAP_HEIGHT, ($urandom() & 32'hFFFF_0000) | 32'(hsel));
            if ($urandom_range(1)) begin
                roll = $urandom_range(9);
                write_reg(CFG_ORG_X, (roll == 0) ? SAT_MAX : (roll == 1) ? SAT_MIN : $urandom());
            end
            if ($urandom_range(1)) begin
                roll = $urandom_range(9);
                write_reg(CFG_ORG_Y, (roll == 0) ? SAT_MAX : (roll == 1) ? SAT_MIN : $urandom());
            end
            if ($urandom_range(1)) begin
                roll = $urandom_range(19);
                write_reg(CFG_CELL_SIZE, (roll < 2) ? 32'hFFFF_FFFF : (roll == 2) ? 32'd0 :
                          (roll < 12) ? 32'($urandom_range(1, 1 << 18)) : $urandom());
            end
            if ($urandom_range(99) < 15)
                write_reg(CFG_IDX_W'($urandom_range(CFG_UNUSED_LO, CFG_UNUSED_HI)), $urandom());

            w     = eff_width();
            h     = eff_height();
            total = w * h + w + 1;
            limit = total;
            // a tall map only gets a few rows before the next restart
            if (h == TALL_HEIGHT) limit = 3 * w;
            // the wide map runs past its row wrap into the first flush ticks
            else if (frame_no == WIDE_FRAME) limit = w + WIDE_TAIL;
            else if (!dense && $urandom_range(99) < 8)
                limit = $urandom_range(1, total - 1);
            // hold the result side long enough to back up into full
            if (dense) hold_left = HOLD_CYCLES;

            for (i = 0; i < limit; i++) begin
                if (dense) begin
                    m = MODE_CELL;
                    v = ((i % w + i / w) % 2) ? CELL_FREE : CELL_UNKNOWN;
                end else if (i < w * h) begin
                    m    = ($urandom_range(99) < 4) ? MODE_FLUSH : MODE_CELL;
                    roll = $urandom_range(99);
                    v    = (roll < 45) ? CELL_FREE : (roll < 75) ? CELL_UNKNOWN :
                           8'($urandom_range(255));
                end else begin
                    m = ($urandom_range(99) < 10) ? MODE_CELL : MODE_FLUSH;
                    v = 8'($urandom_range(255));
                end
                send_item(m, v, ROW_ITEM, NO_HIT);
                if (frame_no == PAUSE_FRAME && i == limit / 2) pause_for_results();
            end
            cells_sent += limit;
            frame_no++;
        end

        pause_for_results();
        repeat (TAIL) @(posedge i_clk);
        if (errors == 0 && pending_frontiers.size() == 0) begin
            $display("tb_occupancy_frontier_detector: clean");
        end else begin
            $display("tb_occupancy_frontier_detector: errors");
        end
        $finish;
    end

endmodule
